### rtl/rcwc_pkg.sv
// ----------------------------------------------------------------------------
// rcwc_pkg: shared types and constants for the Reno congestion window control
// Event kinds, congestion phases, result word layout and saturating helpers.
// ----------------------------------------------------------------------------
package rcwc_pkg;

    localparam int SEQ_BITS  = 16;
    localparam int DUP_BITS  = 8;
    localparam int IDX_BITS  = 1;

    typedef logic [SEQ_BITS-1:0] seq_t;
    typedef logic [DUP_BITS-1:0] dup_t;

    localparam seq_t SEQ_MAX          = {SEQ_BITS{1'b1}};
    localparam seq_t WIN_MAX          = 16'd65535;
    localparam seq_t SSTHRESH_DEFAULT = 16'd50;
    localparam seq_t FR_BOOST         = 16'd3;
    localparam dup_t DUP_LIMIT        = 8'd3;
    localparam dup_t DUP_MAX          = {DUP_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] REG_TOTAL_SEGMENTS   = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_INITIAL_SSTHRESH = 1'b1;

    typedef enum logic [1:0] {
        MODE_SEND    = 2'd0,
        MODE_ACK     = 2'd1,
        MODE_TIMEOUT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_SLOW_START = 2'd0,
        PH_AVOID      = 2'd1,
        PH_RECOVERY   = 2'd2
    } phase_t;

    // One result word, last field in the lowest bits, padded to 88 bits.
    typedef struct packed {
        logic [1:0] pad;
        logic       done_res;
        logic [1:0] phase;
        seq_t       threshold_now;
        seq_t       window_now;
        seq_t       resend_count;
        seq_t       resend_first;
        logic       resend_now;
        logic       restart_timer;
        seq_t       send_seq;
        logic       send_grant;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);

    // Window increment that stops at the largest window.
    function automatic seq_t win_inc(input seq_t w);
        seq_t r;
        if (w < WIN_MAX)
        begin
            r = w + 16'd1;
        end
        else
        begin
            r = WIN_MAX;
        end
        return r;
    endfunction

    // Half of the window, rounded up.
    function automatic seq_t half_up(input seq_t w);
        logic [SEQ_BITS:0] s;
        s = {1'b0, w} + {{SEQ_BITS{1'b0}}, 1'b1};
        return s[SEQ_BITS:1];
    endfunction

endpackage

### rtl/reno_congestion_window_control_top.sv
// ----------------------------------------------------------------------------
// reno_congestion_window_control_top: go-back-N sender window control
// Takes one event word per cycle while s_axis_tready is high (send request,
// acknowledgement or retransmit timeout) and returns one result word per
// event. The window base, next sequence number, cwnd, ssthresh, phase and
// duplicate-ack tracking live in flip-flops and are all updated by a single
// pass of logic in the cycle the event word is accepted, so a new event can
// enter every clock; its result is registered in the output register, and
// s_axis_tready stays high as long as that register is empty or being
// drained. Throughput is one event per cycle while it does, set by the
// single-pass state update loop. Configuration words are taken at any time
// (cfg_ready is always high) but should only be written while no event is in
// flight; writing initial_ssthresh also loads ssthresh at once, a zero
// counting as one.
// ----------------------------------------------------------------------------
module reno_congestion_window_control_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Event channel.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // ack_num[15:0]
    input  logic [2:0]                     s_axis_tuser,   // mode[1:0], ack_ok[2]
    // Result channel.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // send_grant[0], send_seq[16:1], restart_timer[17], resend_now[18],
    // resend_first[34:19], resend_count[50:35], window_now[66:51],
    // threshold_now[82:67], phase[84:83], done_res[85], zero pad[87:86]
    output logic [rcwc_pkg::RESULT_BITS-1:0] m_axis_tdata,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcwc_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data
);

    import rcwc_pkg::*;

    // Configuration and protocol state.
    seq_t    total_segments_reg;
    seq_t    window_base_reg,    window_base_next;
    seq_t    next_seq_reg,       next_seq_next;
    seq_t    cong_window_reg,    cong_window_next;
    seq_t    slow_threshold_reg, slow_threshold_next;
    phase_t  cc_phase_reg,       cc_phase_next;
    seq_t    last_ack_reg,       last_ack_next;
    logic    last_ack_seen_reg,  last_ack_seen_next;
    dup_t    dup_count_reg,      dup_count_next;
    seq_t    avoid_count_reg,    avoid_count_next;
    seq_t    recover_point_reg,  recover_point_next;
    logic    finished_reg,       finished_next;

    // Output register.
    logic    out_valid_reg;
    result_t out_word_reg;
    result_t res;

    logic    in_fire;
    mode_t   ev_mode;
    seq_t    ev_ack;
    logic    ev_ok;
    logic    dup;
    logic    grant;
    logic    restart;
    logic    resend;
    seq_t    cw_step;
    seq_t    avoid_step;
    seq_t    fr_thresh;
    logic [SEQ_BITS:0] fr_sum;
    logic [SEQ_BITS:0] ack_plus;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign ev_mode  = mode_t'(s_axis_tuser[1:0]);
    assign ev_ok    = s_axis_tuser[2];
    assign ev_ack   = s_axis_tdata;
    assign ack_plus = {1'b0, ev_ack} + {{SEQ_BITS{1'b0}}, 1'b1};

    // Fast recovery entry values; on entry the window is unchanged since the
    // triggering ack is a duplicate.
    assign fr_thresh = half_up(cong_window_reg);
    assign fr_sum    = {1'b0, fr_thresh} + {1'b0, FR_BOOST};

    always_comb
    begin
        window_base_next    = window_base_reg;
        next_seq_next       = next_seq_reg;
        cong_window_next    = cong_window_reg;
        slow_threshold_next = slow_threshold_reg;
        cc_phase_next       = cc_phase_reg;
        last_ack_next       = last_ack_reg;
        last_ack_seen_next  = last_ack_seen_reg;
        dup_count_next      = dup_count_reg;
        avoid_count_next    = avoid_count_reg;
        recover_point_next  = recover_point_reg;
        finished_next       = finished_reg;
        grant               = 1'b0;
        restart             = 1'b0;
        resend              = 1'b0;
        dup                 = last_ack_seen_reg && (last_ack_reg == ev_ack);
        cw_step             = win_inc(cong_window_reg);
        avoid_step          = avoid_count_reg + 16'd1;

        if (in_fire && !finished_reg)
        begin
            unique case (ev_mode)
                MODE_SEND:
                begin
                    if (((next_seq_reg - window_base_reg) < cong_window_reg) &&
                        (next_seq_reg < total_segments_reg) &&
                        (next_seq_reg < SEQ_MAX))
                    begin
                        grant         = 1'b1;
                        restart       = (window_base_reg == next_seq_reg);
                        next_seq_next = next_seq_reg + 16'd1;
                    end
                end
                MODE_ACK:
                begin
                    if (ev_ok && (ev_ack < next_seq_reg))
                    begin
                        if (ev_ack >= window_base_reg)
                        begin
                            window_base_next = ack_plus[SEQ_BITS-1:0];
                        end
                        restart = (window_base_next != next_seq_reg);
                        if (ack_plus == {1'b0, total_segments_reg})
                        begin
                            // Final segment acknowledged: no congestion update.
                            finished_next = 1'b1;
                        end
                        else
                        begin
                            if (dup)
                            begin
                                if (dup_count_reg < DUP_MAX)
                                begin
                                    dup_count_next = dup_count_reg + 8'd1;
                                end
                            end
                            else
                            begin
                                last_ack_next      = ev_ack;
                                last_ack_seen_next = 1'b1;
                                dup_count_next     = '0;
                            end

                            unique case (cc_phase_reg)
                                PH_SLOW_START:
                                begin
                                    if (!dup)
                                    begin
                                        cong_window_next = cw_step;
                                    end
                                    if (dup_count_next == DUP_LIMIT)
                                    begin
                                        resend              = 1'b1;
                                        cc_phase_next       = PH_RECOVERY;
                                        slow_threshold_next = fr_thresh;
                                        cong_window_next    = fr_sum[SEQ_BITS] ? WIN_MAX
                                                              : fr_sum[SEQ_BITS-1:0];
                                        recover_point_next  = next_seq_reg - 16'd1;
                                    end
                                    else if (cong_window_next >= slow_threshold_reg)
                                    begin
                                        avoid_count_next = '0;
                                        cc_phase_next    = PH_AVOID;
                                    end
                                end
                                PH_AVOID:
                                begin
                                    if (!dup)
                                    begin
                                        if (avoid_step >= cong_window_reg)
                                        begin
                                            cong_window_next = cw_step;
                                            avoid_count_next = '0;
                                        end
                                        else
                                        begin
                                            avoid_count_next = avoid_step;
                                        end
                                    end
                                    if (dup_count_next == DUP_LIMIT)
                                    begin
                                        resend              = 1'b1;
                                        cc_phase_next       = PH_RECOVERY;
                                        slow_threshold_next = fr_thresh;
                                        cong_window_next    = fr_sum[SEQ_BITS] ? WIN_MAX
                                                              : fr_sum[SEQ_BITS-1:0];
                                        recover_point_next  = next_seq_reg - 16'd1;
                                    end
                                end
                                PH_RECOVERY:
                                begin
                                    if (!dup)
                                    begin
                                        cong_window_next = cw_step;
                                    end
                                    if (dup_count_next == DUP_LIMIT)
                                    begin
                                        resend = 1'b1;
                                    end
                                    // Recovery ends once the recovery point is acked.
                                    if (ev_ack >= recover_point_reg)
                                    begin
                                        avoid_count_next = '0;
                                        cong_window_next = slow_threshold_reg;
                                        cc_phase_next    = PH_AVOID;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
                MODE_TIMEOUT:
                begin
                    slow_threshold_next = fr_thresh;
                    cong_window_next    = 16'd1;
                    cc_phase_next       = PH_SLOW_START;
                    resend              = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        res               = '0;
        res.send_grant    = grant;
        res.send_seq      = grant ? next_seq_reg : '0;
        res.restart_timer = restart || resend;
        res.resend_now    = resend;
        res.resend_first  = resend ? window_base_next : '0;
        res.resend_count  = resend ? (next_seq_next - window_base_next) : '0;
        res.window_now    = cong_window_next;
        res.threshold_now = slow_threshold_next;
        res.phase         = cc_phase_next;
        res.done_res      = finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_segments_reg <= 16'd1;
            window_base_reg    <= '0;
            next_seq_reg       <= '0;
            cong_window_reg    <= 16'd1;
            slow_threshold_reg <= SSTHRESH_DEFAULT;
            cc_phase_reg       <= PH_SLOW_START;
            last_ack_reg       <= '0;
            last_ack_seen_reg  <= 1'b0;
            dup_count_reg      <= '0;
            avoid_count_reg    <= '0;
            recover_point_reg  <= '0;
            finished_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            window_base_reg    <= window_base_next;
            next_seq_reg       <= next_seq_next;
            cong_window_reg    <= cong_window_next;
            cc_phase_reg       <= cc_phase_next;
            last_ack_reg       <= last_ack_next;
            last_ack_seen_reg  <= last_ack_seen_next;
            dup_count_reg      <= dup_count_next;
            avoid_count_reg    <= avoid_count_next;
            recover_point_reg  <= recover_point_next;
            finished_reg       <= finished_next;

            // A threshold write takes the place of the event update.
            if (cfg_valid && cfg_ready && (cfg_index == REG_INITIAL_SSTHRESH))
            begin
                slow_threshold_reg <= (cfg_data == '0) ? 16'd1 : cfg_data;
            end
            else
            begin
                slow_threshold_reg <= slow_threshold_next;
            end

            if (cfg_valid && cfg_ready && (cfg_index == REG_TOTAL_SEGMENTS))
            begin
                total_segments_reg <= cfg_data;
            end

            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_word_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;

    // The base never runs past the next sequence number.
    a_base_le_next: assert property (@(posedge clk) disable iff (!rst_n)
        window_base_reg <= next_seq_reg)
        else $error("window base beyond next sequence number");

    // cwnd and ssthresh never drop to zero.
    a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cong_window_reg != '0) && (slow_threshold_reg != '0))
        else $error("cwnd or ssthresh reached zero");

    // Once finished, the transfer stays finished.
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared");

    // A resend always restarts the timer, and no resend leaves its fields zero.
    a_resend_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.resend_now ? out_word_reg.restart_timer
                           : ((out_word_reg.resend_first == '0) &&
                              (out_word_reg.resend_count == '0))))
        else $error("inconsistent resend result");

    // A grant is only given while the transfer is still running.
    a_grant_running: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && finished_reg) |=> !out_word_reg.send_grant)
        else $error("grant after the transfer finished");

endmodule

### tb/reno_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reno window checker
// Watches the event, result and configuration channels of the congestion
// window block, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module reno_window_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,   // ack_num[15:0]
    input  logic [2:0]                        s_axis_tuser,   // mode[1:0], ack_ok[2]
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [rcwc_pkg::RESULT_BITS-1:0]  m_axis_tdata,   // result_t layout
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [rcwc_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data,
    output int                                mismatches,
    output int                                outstanding,
    output int                                events_seen,
    output int                                grants_seen,
    output int                                resends_seen,
    output rcwc_pkg::seq_t                    next_seq_hint,
    output rcwc_pkg::seq_t                    base_hint
);

    import rcwc_pkg::*;

    seq_t    seg_total;
    seq_t    win_base;
    seq_t    nxt;
    seq_t    cwnd;
    seq_t    ssth;
    seq_t    prev_ack;
    seq_t    avoid_cnt;
    seq_t    recover_at;
    phase_t  cc;
    logic    ack_seen;
    logic    xfer_done;
    dup_t    dups;

    result_t due_results[$];
    int      err_cnt;
    int      ev_cnt;
    int      gr_cnt;
    int      rs_cnt;

    function automatic seq_t grow(input seq_t w);
        return (w == WIN_MAX) ? w : w + 16'd1;
    endfunction

    function automatic seq_t ceil_half(input seq_t w);
        logic [16:0] s;
        s = {1'b0, w} + 17'd1;
        return s[16:1];
    endfunction

    task automatic reset_model();
        seg_total  = 16'd1;
        win_base   = '0;
        nxt        = '0;
        cwnd       = 16'd1;
        ssth       = SSTHRESH_DEFAULT;
        prev_ack   = '0;
        avoid_cnt  = '0;
        recover_at = '0;
        cc         = PH_SLOW_START;
        ack_seen   = 1'b0;
        xfer_done  = 1'b0;
        dups       = '0;
    endtask

    task automatic enter_recovery();
        logic [16:0] boosted;
        cc         = PH_RECOVERY;
        ssth       = ceil_half(cwnd);
        boosted    = {1'b0, ssth} + {1'b0, FR_BOOST};
        cwnd       = boosted[16] ? WIN_MAX : boosted[15:0];
        recover_at = nxt - 16'd1;
    endtask

    // Applies one event word to the shadow state and builds its result word.
    task automatic advance_window(input logic [1:0] mode, input seq_t ack, input logic ok,
                                  output result_t r);
        logic        grant;
        logic        restart;
        logic        resend;
        logic        dup;
        logic [16:0] ack_plus;
        seq_t        sseq;
        grant    = 1'b0;
        restart  = 1'b0;
        resend   = 1'b0;
        sseq     = '0;
        ack_plus = {1'b0, ack} + 17'd1;
        if (!xfer_done && mode == MODE_SEND)
        begin
            if ((nxt - win_base) < cwnd && nxt < seg_total && nxt != SEQ_MAX)
            begin
                grant = 1'b1;
                sseq  = nxt;
                if (win_base == nxt)
                begin
                    restart = 1'b1;
                end
                nxt = nxt + 16'd1;
            end
        end
        else if (!xfer_done && mode == MODE_ACK && ok && ack < nxt)
        begin
            if (ack >= win_base)
            begin
                win_base = ack_plus[15:0];
            end
            if (win_base != nxt)
            begin
                restart = 1'b1;
            end
            if (ack_plus == {1'b0, seg_total})
            begin
                xfer_done = 1'b1;
            end
            else
            begin
                dup = ack_seen && prev_ack == ack;
                if (dup)
                begin
                    if (dups != DUP_MAX)
                    begin
                        dups = dups + 8'd1;
                    end
                end
                else
                begin
                    prev_ack = ack;
                    ack_seen = 1'b1;
                    dups     = '0;
                end
                case (cc)
                    PH_SLOW_START:
                    begin
                        if (!dup)
                        begin
                            cwnd = grow(cwnd);
                        end
                        if (dups == DUP_LIMIT)
                        begin
                            resend = 1'b1;
                            enter_recovery();
                        end
                        else if (cwnd >= ssth)
                        begin
                            avoid_cnt = '0;
                            cc        = PH_AVOID;
                        end
                    end
                    PH_AVOID:
                    begin
                        if (!dup)
                        begin
                            avoid_cnt = avoid_cnt + 16'd1;
                            if (avoid_cnt >= cwnd)
                            begin
                                cwnd      = grow(cwnd);
                                avoid_cnt = '0;
                            end
                        end
                        if (dups == DUP_LIMIT)
                        begin
                            resend = 1'b1;
                            enter_recovery();
                        end
                    end
                    PH_RECOVERY:
                    begin
                        if (!dup)
                        begin
                            cwnd = grow(cwnd);
                        end
                        if (dups == DUP_LIMIT)
                        begin
                            resend = 1'b1;
                        end
                        // Recovery ends once the ack covers the highest segment
                        // that was outstanding when recovery began.
                        if (ack >= recover_at)
                        begin
                            avoid_cnt = '0;
                            cwnd      = ssth;
                            cc        = PH_AVOID;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (!xfer_done && mode == MODE_TIMEOUT)
        begin
            ssth   = ceil_half(cwnd);
            cwnd   = 16'd1;
            cc     = PH_SLOW_START;
            resend = 1'b1;
        end

        r               = '0;
        r.send_grant    = grant;
        r.send_seq      = sseq;
        r.restart_timer = restart | resend;
        r.resend_now    = resend;
        r.resend_first  = resend ? win_base : '0;
        r.resend_count  = resend ? (nxt - win_base) : '0;
        r.window_now    = cwnd;
        r.threshold_now = ssth;
        r.phase         = cc;
        r.done_res      = xfer_done;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            reset_model();
            due_results.delete();
            err_cnt = 0;
            ev_cnt  = 0;
            gr_cnt  = 0;
            rs_cnt  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TOTAL_SEGMENTS)
                begin
                    seg_total = cfg_data;
                end
                else if (cfg_index == REG_INITIAL_SSTHRESH)
                begin
                    ssth = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_window(s_axis_tuser[1:0], s_axis_tdata, s_axis_tuser[2], want);
                due_results.push_back(want);
                ev_cnt++;
                if (want.send_grant)
                begin
                    gr_cnt++;
                end
                if (want.resend_now)
                begin
                    rs_cnt++;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (due_results.size() == 0)
                begin
                    $display("%0t: result word with no prediction waiting, expected none, actual %h",
                             $time, m_axis_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("send_grant", want.send_grant, got.send_grant);
                    check_field("send_seq", want.send_seq, got.send_seq);
                    check_field("restart_timer", want.restart_timer, got.restart_timer);
                    check_field("resend_now", want.resend_now, got.resend_now);
                    check_field("resend_first", want.resend_first, got.resend_first);
                    check_field("resend_count", want.resend_count, got.resend_count);
                    check_field("window_now", want.window_now, got.window_now);
                    check_field("threshold_now", want.threshold_now, got.threshold_now);
                    check_field("phase", want.phase, got.phase);
                    check_field("done_res", want.done_res, got.done_res);
                end
            end
        end
        mismatches    <= err_cnt;
        outstanding   <= due_results.size();
        events_seen   <= ev_cnt;
        grants_seen   <= gr_cnt;
        resends_seen  <= rs_cnt;
        next_seq_hint <= nxt;
        base_hint     <= win_base;
    end

endmodule

### tb/tb_reno_congestion_window_control_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Reno congestion window control block
// Drives send, acknowledgement and timeout words through the event stream,
// rewrites the two configuration registers between phases and leaves the
// prediction and comparison of every result word to the checker module.
// ----------------------------------------------------------------------------
module tb_reno_congestion_window_control_top;

    import rcwc_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 195;
    localparam int STALL_CYCLES = 300;
    localparam int DUP_FLOOD    = 260;
    // The event kind field has one code that the block does not define.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [15:0]              s_axis_tdata  = '0;
    logic [2:0]               s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b1;
    logic [RESULT_BITS-1:0]   m_axis_tdata;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [IDX_BITS-1:0]      cfg_index     = '0;
    logic [15:0]              cfg_data      = '0;

    int   mismatches;
    int   outstanding;
    int   events_seen;
    int   grants_seen;
    int   resends_seen;
    seq_t next_seq_hint;
    seq_t base_hint;

    // Stimulus control shared by the sender and the receiver processes.
    logic idle_on        = 1'b0;
    int   stall_req      = 0;
    int   stall_served   = 0;
    int   cycles         = 0;
    int   items_sent     = 0;
    int   settings_used  = 0;
    seq_t seg_total      = 16'd1;
    seq_t last_good_ack  = '0;

    always #HALF_PERIOD clk = ~clk;

    reno_congestion_window_control_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    reno_window_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .events_seen   (events_seen),
        .grants_seen   (grants_seen),
        .resends_seen  (resends_seen),
        .next_seq_hint (next_seq_hint),
        .base_hint     (base_hint)
    );

    // The run is bounded by a plain cycle count, far above the slowest
    // legal run with every gap and stall at its longest.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d predictions waiting", cycles, outstanding);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offers one event word and returns at the edge where it is accepted.
    // The valid is only lowered when a gap is inserted, so a word that follows
    // directly never sees valid dropped and raised in the same time step.
    task automatic put_event(input logic [1:0] mode, input seq_t ack, input logic ok);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ack;
        s_axis_tuser  <= {ok, mode};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (mode == MODE_ACK && ok && ack < next_seq_hint)
        begin
            last_good_ack = ack;
        end
    endtask

    // Picks one event in the way a real sender sees them: mostly send
    // requests and in-window acks, with duplicate runs, timeouts and noise.
    // The window hints lag by at most one word, which only makes a few acks
    // land outside the window.
    task automatic rand_event();
        int         pick;
        int         span;
        int         reps;
        logic [1:0] mode;
        seq_t       ack;
        logic       ok;
        pick = $urandom_range(0, 99);
        mode = MODE_SEND;
        ack  = seq_t'($urandom);
        ok   = 1'($urandom);
        reps = 1;
        if (pick < 40 || next_seq_hint == 16'd0)
        begin
            mode = MODE_SEND;
        end
        else if (pick < 72)
        begin
            mode = MODE_ACK;
            ok   = 1'b1;
            if (next_seq_hint > base_hint)
            begin
                span = next_seq_hint - base_hint;
                ack  = base_hint + seq_t'($urandom_range(0, (span > 3) ? 2 : span - 1));
            end
            else
            begin
                ack = seq_t'($urandom_range(0, next_seq_hint - 1));
            end
        end
        else if (pick < 85)
        begin
            // A short run of repeats of the last good ack, often enough to
            // reach the third duplicate.
            mode = MODE_ACK;
            ok   = 1'b1;
            ack  = last_good_ack;
            reps = $urandom_range(1, 5);
        end
        else if (pick < 90)
        begin
            mode = MODE_TIMEOUT;
        end
        else if (pick < 95)
        begin
            mode = MODE_ACK;
            ok   = 1'b0;
        end
        else if (pick < 98)
        begin
            mode = MODE_ACK;
            ok   = 1'b1;
            ack  = seq_t'($urandom_range(next_seq_hint, 16'hFFFF));
        end
        else
        begin
            mode = MODE_UNUSED;
        end
        // The final ack would freeze the block for good, so it is kept for
        // the closing part of the run and turned into a corrupted ack here.
        if (mode == MODE_ACK && ok && ({1'b0, ack} + 17'd1) == {1'b0, seg_total})
        begin
            ok = 1'b0;
        end
        repeat (reps) put_event(mode, ack, ok);
    endtask

    // Writes both registers back to back; valid stays high between them.
    task automatic configure(input seq_t total, input seq_t thresh);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TOTAL_SEGMENTS;
        cfg_data  <= total;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_index <= REG_INITIAL_SSTHRESH;
        cfg_data  <= thresh;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        seg_total = total;
        settings_used++;
    endtask

    // Stops offering words, waits until every predicted word has come back
    // through the result register and then idles before returning.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Result side: random stalls while idling is on, and one long hold-off
    // on request so that the output register fills and the input stalls.
    initial
    begin : receiver
        int hold;
        forever
        begin
            @(posedge clk);
            if (stall_req != stall_served)
            begin
                stall_served = stall_req;
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int phase_idx;
        int phase_start;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Transfer of a single segment: the window and the segment limit
        // both close after the first send.
        configure(16'd1, SSTHRESH_DEFAULT);
        put_event(MODE_TIMEOUT, 16'd0, 1'b0);      // timeout with nothing outstanding
        put_event(MODE_SEND, 16'd0, 1'b0);         // first send restarts the timer
        put_event(MODE_SEND, 16'hFFFF, 1'b1);      // refused, no segments left
        put_event(MODE_ACK, 16'd0, 1'b0);          // corrupted ack changes nothing
        put_event(MODE_ACK, 16'd1, 1'b1);          // ack for a segment never sent
        put_event(MODE_UNUSED, 16'hFFFF, 1'b1);    // undefined event kind
        put_event(MODE_TIMEOUT, 16'h5A5A, 1'b1);   // timeout with one outstanding
        settle();

        // Long transfer with the largest threshold: slow start, a triple
        // duplicate into fast recovery, recovery exit and a timeout.
        configure(WIN_MAX, 16'hFFFF);
        put_event(MODE_SEND, 16'd0, 1'b0);         // window still full
        put_event(MODE_ACK, 16'd0, 1'b1);          // first good ack opens the window
        put_event(MODE_SEND, 16'd0, 1'b0);
        put_event(MODE_SEND, 16'd0, 1'b0);
        put_event(MODE_SEND, 16'd0, 1'b0);         // window full again
        put_event(MODE_ACK, 16'd1, 1'b1);
        put_event(MODE_ACK, 16'd1, 1'b1);
        put_event(MODE_ACK, 16'd1, 1'b1);
        put_event(MODE_ACK, 16'd1, 1'b1);          // third duplicate asks for a resend
        put_event(MODE_ACK, 16'hFFFF, 1'b1);       // far beyond the sent segments
        put_event(MODE_SEND, 16'd0, 1'b0);
        put_event(MODE_ACK, 16'd2, 1'b1);          // covers the recovery point
        put_event(MODE_TIMEOUT, 16'd0, 1'b0);
        put_event(MODE_ACK, 16'd3, 1'b1);
        settle();

        for (phase_idx = 0; phase_idx < 6; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    idle_on = 1'b1;
                    configure(WIN_MAX, SSTHRESH_DEFAULT);
                end
                1:
                begin
                    // A stretch with no idling on either side.
                    idle_on = 1'b0;
                    configure(WIN_MAX, 16'd1);
                end
                2:
                begin
                    idle_on = 1'b1;
                    configure(WIN_MAX, seq_t'($urandom_range(2, 40)));
                    // The receiver now holds off for a long time while the
                    // sender keeps offering words.
                    stall_req <= stall_req + 1;
                end
                3:
                begin
                    // Only a handful of segments remain, so sends run into
                    // the segment limit.
                    configure(next_seq_hint + 16'd6, 16'hFFFF);
                end
                4:
                begin
                    configure(WIN_MAX, seq_t'($urandom_range(1, 65535)));
                    // A long run of one duplicate drives the duplicate
                    // counter into saturation.
                    repeat (DUP_FLOOD) put_event(MODE_ACK, last_good_ack, 1'b1);
                end
                default:
                begin
                    // Closing part of the run, with no idling at all.
                    idle_on = 1'b0;
                    configure(WIN_MAX, 16'd8);
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                rand_event();
            end
            settle();
        end

        // Make the most recently sent segment the last one, acknowledge it
        // and check that everything after the finish is ignored.
        configure(next_seq_hint, SSTHRESH_DEFAULT);
        put_event(MODE_ACK, next_seq_hint - 16'd1, 1'b1);
        put_event(MODE_SEND, 16'd0, 1'b0);
        put_event(MODE_TIMEOUT, 16'd0, 1'b0);
        put_event(MODE_ACK, 16'd0, 1'b1);
        settle();

        $display("Run covered %0d event words over %0d register settings: %0d sends granted, %0d resends.",
                 events_seen, settings_used, grants_seen, resends_seen);
        $display("Mismatches: %0d, predictions left waiting: %0d.", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
